// File: rtl/jsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package jsu_pkg;

	localparam int unsigned MAX_CAPACITY = 1024;
	localparam int unsigned CAP_W        = 11;
	localparam int unsigned CP_W         = 21;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_ACCEPT = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		PH_NORMAL,
		PH_ESC,
		PH_UHEX,
		PH_SBS,
		PH_SU,
		PH_SHEX,
		PH_UTF8
	} phase_t;

	// One decoded item: up to four UTF-8 bytes, then an optional verdict.
	// verdict of KIND_DATA means no verdict follows the bytes.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      n;
		kind_t           verdict;
	} job_t;

endpackage
`default_nettype wire

// File: rtl/jsu_front.sv
`timescale 1ns / 1ps
`default_nettype none
module jsu_front import jsu_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [7:0]       in_byte,
	input  wire logic             byte_present,
	input  wire logic             end_of_string,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CAP_W-1:0] out_capacity,
	input  wire logic             full,
	output logic                  push,
	output job_t                  job
);

	logic [CAP_W-1:0] out_capacity_q;
	phase_t           phase_q, phase_d;
	logic [CP_W-1:0]  cp_q, cp_d;
	logic [1:0]       left_q, left_d;
	logic [1:0]       total_q, total_d;
	logic [CAP_W-1:0] bw_q, bw_d;
	logic             saw_q, saw_d;
	logic             failed_q, failed_d;

	logic             in_acc;
	logic             take;
	logic             dec_fail;
	logic             emit_req;
	logic [CP_W-1:0]  emit_cp;
	logic [4:0]       hv;
	logic [15:0]      cp16;
	logic [CP_W-1:0]  cp_cont;
	logic [CP_W-1:0]  cp_low;
	logic [CP_W-1:0]  minv;

	logic [2:0]       enc_n;
	logic [3:0][7:0]  enc_b;
	logic [CAP_W-1:0] cap_eff;
	logic [CAP_W:0]   bw_sum;
	logic             bad_cp;
	logic             emit_ok;
	logic             ok;

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		case (c) inside
			[8'h30:8'h39]: r = {1'b1, 4'(c - 8'h30)};
			[8'h61:8'h66]: r = {1'b1, 4'(c - 8'h57)};
			[8'h41:8'h46]: r = {1'b1, 4'(c - 8'h37)};
			default:       r = '0;
		endcase
		return r;
	endfunction

	assign in_stall  = full;
	assign in_acc    = in_valid && !full;
	assign cfg_ready = 1'b1;
	assign take      = byte_present && !failed_q;

	assign hv      = hex_val(in_byte);
	assign cp16    = {cp_q[11:0], hv[3:0]};
	assign cp_cont = {cp_q[CP_W-7:0], in_byte[5:0]};
	assign cp_low  = cp_q | {{(CP_W-4){1'b0}}, hv[3:0]};

	always_comb begin
		case (total_q)
			2'd1:    minv = CP_W'(32'h80);
			2'd2:    minv = CP_W'(32'h800);
			default: minv = CP_W'(32'h10000);
		endcase
	end

	// decode: next state of the string decoder and the code point to emit
	always_comb begin
		phase_d  = phase_q;
		cp_d     = cp_q;
		left_d   = left_q;
		total_d  = total_q;
		dec_fail = 1'b0;
		emit_req = 1'b0;
		emit_cp  = '0;
		if (take) begin
			case (phase_q)
				PH_NORMAL: begin
					if (in_byte == CH_BSLASH) begin
						phase_d = PH_ESC;
					end else if (!in_byte[7]) begin
						emit_req = 1'b1;
						emit_cp  = CP_W'(in_byte);
					end else begin
						case (in_byte) inside
							[8'hc2:8'hdf]: begin
								cp_d    = CP_W'(in_byte[4:0]);
								left_d  = 2'd1;
								total_d = 2'd1;
								phase_d = PH_UTF8;
							end
							[8'he0:8'hef]: begin
								cp_d    = CP_W'(in_byte[3:0]);
								left_d  = 2'd2;
								total_d = 2'd2;
								phase_d = PH_UTF8;
							end
							[8'hf0:8'hf4]: begin
								cp_d    = CP_W'(in_byte[2:0]);
								left_d  = 2'd3;
								total_d = 2'd3;
								phase_d = PH_UTF8;
							end
							default: dec_fail = 1'b1;
						endcase
					end
				end
				PH_ESC: begin
					phase_d = PH_NORMAL;
					case (in_byte) inside
						CH_U: begin
							phase_d = PH_UHEX;
							cp_d    = '0;
							left_d  = 2'd0;
						end
						CH_QUOTE, CH_BSLASH, CH_SLASH: begin
							emit_req = 1'b1;
							emit_cp  = CP_W'(in_byte);
						end
						8'h6e, 8'h72, 8'h74, 8'h62, 8'h66: begin
							emit_req = 1'b1;
							emit_cp  = CP_W'(CH_SPACE);
						end
						default: dec_fail = 1'b1;
					endcase
				end
				PH_UHEX: begin
					if (!hv[4]) begin
						dec_fail = 1'b1;
					end else begin
						cp_d = CP_W'(cp16);
						if (left_q != 2'd3) begin
							left_d = left_q + 2'd1;
						end else begin
							left_d = 2'd0;
							case (cp16) inside
								[16'hd800:16'hdbff]: begin
									cp_d    = CP_W'(32'h10000) + {1'b0, cp16[9:0], 10'b0};
									phase_d = PH_SBS;
								end
								[16'hdc00:16'hdfff]: dec_fail = 1'b1;
								default: begin
									phase_d  = PH_NORMAL;
									emit_req = 1'b1;
									emit_cp  = CP_W'(cp16);
								end
							endcase
						end
					end
				end
				PH_SBS: begin
					if (in_byte != CH_BSLASH) begin
						dec_fail = 1'b1;
					end else begin
						phase_d = PH_SU;
					end
				end
				PH_SU: begin
					if (in_byte != CH_U) begin
						dec_fail = 1'b1;
					end else begin
						phase_d = PH_SHEX;
						left_d  = 2'd0;
					end
				end
				PH_SHEX: begin
					if (!hv[4]) begin
						dec_fail = 1'b1;
					end else begin
						case (left_q)
							2'd0: begin
								if (hv[3:0] != 4'hd) begin
									dec_fail = 1'b1;
								end else begin
									left_d = 2'd1;
								end
							end
							2'd1: begin
								if (hv[3:0] < 4'hc) begin
									dec_fail = 1'b1;
								end else begin
									cp_d   = cp_q | {{(CP_W-10){1'b0}}, hv[1:0], 8'b0};
									left_d = 2'd2;
								end
							end
							2'd2: begin
								cp_d   = cp_q | {{(CP_W-8){1'b0}}, hv[3:0], 4'b0};
								left_d = 2'd3;
							end
							default: begin
								cp_d     = cp_low;
								left_d   = 2'd0;
								phase_d  = PH_NORMAL;
								emit_req = 1'b1;
								emit_cp  = cp_low;
							end
						endcase
					end
				end
				PH_UTF8: begin
					if (in_byte[7:6] != 2'b10) begin
						dec_fail = 1'b1;
					end else begin
						cp_d = cp_cont;
						if (left_q > 2'd1) begin
							left_d = left_q - 2'd1;
						end else begin
							left_d  = 2'd0;
							phase_d = PH_NORMAL;
							if (cp_cont < minv || cp_cont > CP_W'(32'h10ffff) ||
								(cp_cont >= CP_W'(32'hd800) && cp_cont <= CP_W'(32'hdfff))) begin
								dec_fail = 1'b1;
							end else begin
								emit_req = 1'b1;
								emit_cp  = cp_cont;
							end
						end
					end
				end
				default: dec_fail = 1'b1;
			endcase
		end
	end

	// encode the code point, refuse control characters and DEL, and check it against the buffer room
	always_comb begin
		enc_b = '0;
		if (emit_cp < CP_W'(32'h80)) begin
			enc_n    = 3'd1;
			enc_b[0] = emit_cp[7:0];
		end else if (emit_cp < CP_W'(32'h800)) begin
			enc_n    = 3'd2;
			enc_b[0] = {3'b110, emit_cp[10:6]};
			enc_b[1] = {2'b10, emit_cp[5:0]};
		end else if (emit_cp < CP_W'(32'h10000)) begin
			enc_n    = 3'd3;
			enc_b[0] = {4'b1110, emit_cp[15:12]};
			enc_b[1] = {2'b10, emit_cp[11:6]};
			enc_b[2] = {2'b10, emit_cp[5:0]};
		end else begin
			enc_n    = 3'd4;
			enc_b[0] = {5'b11110, emit_cp[20:18]};
			enc_b[1] = {2'b10, emit_cp[17:12]};
			enc_b[2] = {2'b10, emit_cp[11:6]};
			enc_b[3] = {2'b10, emit_cp[5:0]};
		end
		bad_cp  = emit_cp < CP_W'(32) || emit_cp == CP_W'(127);
		cap_eff = (out_capacity_q > CAP_W'(MAX_CAPACITY)) ? CAP_W'(MAX_CAPACITY)
			: out_capacity_q;
		bw_sum  = {1'b0, bw_q} + (CAP_W + 1)'(enc_n);
		emit_ok = emit_req && !bad_cp && (bw_sum < {1'b0, cap_eff});
		bw_d     = emit_ok ? bw_sum[CAP_W-1:0] : bw_q;
		saw_d    = saw_q || (emit_ok && emit_cp != CP_W'(CH_SPACE));
		failed_d = failed_q || dec_fail || (emit_req && !emit_ok);
		ok       = !failed_d && phase_d == PH_NORMAL && bw_d != '0 && saw_d;
	end

	// job handed to the queue
	always_comb begin
		job.bytes   = enc_b;
		job.n       = emit_ok ? enc_n : 3'd0;
		job.verdict = end_of_string ? (ok ? KIND_ACCEPT : KIND_REJECT) : KIND_DATA;
		push        = in_acc && (emit_ok || end_of_string);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_capacity_q <= CAP_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			out_capacity_q <= out_capacity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_NORMAL;
			cp_q     <= '0;
			left_q   <= '0;
			total_q  <= '0;
			bw_q     <= '0;
			saw_q    <= 1'b0;
			failed_q <= 1'b0;
		end else if (in_acc) begin
			if (end_of_string) begin
				phase_q  <= PH_NORMAL;
				cp_q     <= '0;
				left_q   <= '0;
				total_q  <= '0;
				bw_q     <= '0;
				saw_q    <= 1'b0;
				failed_q <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				cp_q     <= cp_d;
				left_q   <= left_d;
				total_q  <= total_d;
				bw_q     <= bw_d;
				saw_q    <= saw_d;
				failed_q <= failed_d;
			end
		end
	end

`ifndef SYNTH
	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q && !(in_acc && end_of_string) |=> failed_q)
		else $error("error flag dropped before end of string");
`endif

endmodule
`default_nettype wire

// File: rtl/jsu_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module jsu_queue import jsu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_data,
	output logic      full,
	output logic      q_valid,
	output job_t      q_data,
	input  wire logic pop
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full    = cnt_q == QCNT_W'(QDEPTH);
	assign q_valid = cnt_q != '0;
	assign q_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// File: rtl/jsu_back.sv
`timescale 1ns / 1ps
`default_nettype none
module jsu_back import jsu_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_valid,
	input  wire job_t       q_data,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic [1:0]      kind,
	output logic            last
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	kind_t      kind_q;
	logic       last_q;
	logic [2:0] idx_q;

	logic       load;
	logic       is_data;
	logic       has_verdict;
	logic       fin;

	assign load        = !out_valid_q || !out_stall;
	assign is_data     = idx_q < q_data.n;
	assign has_verdict = q_data.verdict != KIND_DATA;
	assign fin         = is_data ? (idx_q == 3'(q_data.n - 3'd1) && !has_verdict) : 1'b1;
	assign pop         = load && q_valid && fin;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign kind      = kind_q;
	assign last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= q_valid;
			if (q_valid) begin
				idx_q <= fin ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && q_valid) begin
			out_byte_q <= is_data ? q_data.bytes[idx_q[1:0]] : 8'h00;
			kind_q     <= is_data ? KIND_DATA : q_data.verdict;
			last_q     <= fin;
		end
	end

`ifndef SYNTH
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> idx_q <= q_data.n)
		else $error("byte index ran past the job");
	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q != KIND_DATA |-> last_q)
		else $error("verdict beat not marked last");
`endif

endmodule
`default_nettype wire

// File: rtl/json_string_unescape_utf8_check_core.sv
`timescale 1ns / 1ps
`default_nettype none
// JSON string unescaper with UTF-8 check. Feed the raw bytes of one string
// body, one beat each, with end_of_string on the last beat (an empty string
// is a single beat with byte_present low and end_of_string high). Escapes
// are decoded (\" \\ \/ as themselves, \n \r \t \b \f as a space, \uXXXX
// with surrogate pairs), raw UTF-8 is checked for shortest form, range and
// surrogates, control characters and DEL are refused, and every code point
// leaves as UTF-8 data beats (kind 0). The end beat yields a verdict beat,
// kind 1 accept or kind 2 reject; a reject means the consumer drops the
// data beats it already got for that string. After an error the rest of
// the string is ignored. out_capacity counts the terminator slot, so at
// most out_capacity-1 bytes fit; values above 1024 act as 1024 and 0
// rejects everything. Write it only while the block is idle; cfg_ready is
// always high. Rate: the front end takes one byte every cycle while its
// four-entry job queue has room. Each item that yields output is written
// into the job queue and then into the output register. Each input beat
// yields zero to five output beats (up to four UTF-8 bytes plus the
// verdict), and the back end sends one beat per cycle while out_stall is
// low, so at steady state the output serializer sets the throughput.
module json_string_unescape_utf8_check_core import jsu_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [7:0]       in_byte,
	input  wire logic             byte_present,
	input  wire logic             end_of_string,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [7:0]            out_byte,
	output logic [1:0]            kind,
	output logic                  last,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CAP_W-1:0] out_capacity
);

	// front to queue
	logic full;
	logic push;
	job_t push_job;

	// queue to back
	logic q_valid;
	job_t q_job;
	logic pop;

	// decode each beat into a job of UTF-8 bytes plus an optional verdict
	jsu_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.byte_present  (byte_present),
		.end_of_string (end_of_string),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.out_capacity  (out_capacity),
		.full          (full),
		.push          (push),
		.job           (push_job)
	);

	// hold jobs so the front keeps taking beats while the output is stalled
	jsu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.full      (full),
		.q_valid   (q_valid),
		.q_data    (q_job),
		.pop       (pop)
	);

	// serialize each job into output beats, one per cycle while the output is not stalled
	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.kind      (kind),
		.last      (last)
	);

endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the JSON string unescaper with UTF-8 check.
//
// Approach: drive string bodies one byte per beat and decode each accepted
// beat in a bench-side model. The model's expected output beats wait in a
// queue, and a monitor compares every accepted output beat against the
// oldest entry.
module tb;
	import jsu_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	// Margin after the last expected beat has left, for an item that produces
	// no beat and is still in flight.
	localparam int DRAIN_CYCLES = 12;
	localparam int LONG_HOLD    = 80;

	// One output beat as the block should present it.
	typedef struct {
		logic [7:0] data;
		kind_t      k;
		logic       lst;
	} beat_t;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             in_valid     = 1'b0;
	logic             in_stall;
	logic [7:0]       in_byte      = 8'h00;
	logic             byte_present = 1'b0;
	logic             end_of_string = 1'b0;
	logic             out_valid;
	logic             out_stall    = 1'b0;
	logic [7:0]       out_byte;
	logic [1:0]       kind;
	logic             last;
	logic             cfg_valid    = 1'b0;
	logic             cfg_ready;
	logic [CAP_W-1:0] out_capacity = 11'd256;

	// Expected output beats, oldest first.
	beat_t decoded_q[$];

	// Bench-side copy of the decoder state.
	phase_t      ph;
	logic [20:0] cp_acc;
	logic [1:0]  cont_cnt;
	logic [1:0]  seq_len;
	logic [10:0] n_written;
	logic        had_visible;
	logic        str_bad;
	logic [10:0] cap_reg;

	// Pacing controls shared with the receive process.
	logic idle_on  = 1'b1;
	int   hold_req = 0;

	int n_errors   = 0;
	int n_items    = 0;
	int n_strings  = 0;
	int n_accept   = 0;
	int n_reject   = 0;
	int n_beats    = 0;
	int long_holds = 0;
	int cycles     = 0;

	always #5 clk = ~clk;

	json_string_unescape_utf8_check_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.byte_present (byte_present),
		.end_of_string(end_of_string),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.kind         (kind),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.out_capacity (out_capacity)
	);

	// ---------------------------------------------------------------------
	// Decoder model
	// ---------------------------------------------------------------------

	// Encode a code point as UTF-8; byte 0 goes out first. Return the length.
	function automatic int utf8_encode(input int unsigned cp, output logic [3:0][7:0] b);
		b = '0;
		if (cp < 32'h80) begin
			b[0] = 8'(cp);
			return 1;
		end
		if (cp < 32'h800) begin
			b[0] = 8'(32'hc0 | (cp >> 6));
			b[1] = 8'(32'h80 | (cp & 63));
			return 2;
		end
		if (cp < 32'h10000) begin
			b[0] = 8'(32'he0 | (cp >> 12));
			b[1] = 8'(32'h80 | ((cp >> 6) & 63));
			b[2] = 8'(32'h80 | (cp & 63));
			return 3;
		end
		b[0] = 8'(32'hf0 | (cp >> 18));
		b[1] = 8'(32'h80 | ((cp >> 12) & 63));
		b[2] = 8'(32'h80 | ((cp >> 6) & 63));
		b[3] = 8'(32'h80 | (cp & 63));
		return 4;
	endfunction

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'(8'h30);
		if (c >= "a" && c <= "f") return int'(c) - int'(8'h61) + 10;
		if (c >= "A" && c <= "F") return int'(c) - int'(8'h41) + 10;
		return -1;
	endfunction

	// Validate one code point and emit its data bytes if they still fit,
	// leaving the terminator slot free.
	function automatic void put_code_point(input int unsigned cp, ref beat_t made[$]);
		logic [3:0][7:0] b;
		beat_t bt;
		int n, lim, i;
		if (cp < 32 || cp == 127) begin
			str_bad = 1'b1;
			return;
		end
		n = utf8_encode(cp, b);
		lim = (cap_reg > MAX_CAPACITY) ? int'(MAX_CAPACITY) : int'(cap_reg);
		if (int'(n_written) + n >= lim) begin
			str_bad = 1'b1;
			return;
		end
		for (i = 0; i < n; i++) begin
			bt.data = b[i];
			bt.k    = KIND_DATA;
			bt.lst  = 1'b0;
			made.push_back(bt);
			if (b[i] != CH_SPACE) had_visible = 1'b1;
		end
		n_written = n_written + 11'(n);
	endfunction

	// Advance the decoder by one raw byte.
	function automatic void decode_byte(input logic [7:0] c, ref beat_t made[$]);
		int d;
		int unsigned minv;
		case (ph)
			PH_NORMAL: begin
				if (c == CH_BSLASH) begin
					ph = PH_ESC;
				end else if (c < 8'h80) begin
					put_code_point(c, made);
				end else begin
					if (c >= 8'hc2 && c <= 8'hdf) seq_len = 2'd1;
					else if (c >= 8'he0 && c <= 8'hef) seq_len = 2'd2;
					else if (c >= 8'hf0 && c <= 8'hf4) seq_len = 2'd3;
					else begin
						str_bad = 1'b1;
						return;
					end
					cp_acc   = {13'd0, c & (8'hff >> (int'(seq_len) + 2))};
					cont_cnt = seq_len;
					ph       = PH_UTF8;
				end
			end
			PH_ESC: begin
				ph = PH_NORMAL;
				if (c == CH_U) begin
					ph       = PH_UHEX;
					cp_acc   = '0;
					cont_cnt = '0;
				end else if (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH) begin
					put_code_point(c, made);
				end else if (c == "n" || c == "r" || c == "t" || c == "b" || c == "f") begin
					put_code_point(CH_SPACE, made);
				end else begin
					str_bad = 1'b1;
				end
			end
			PH_UHEX: begin
				d = hex_digit(c);
				if (d < 0) begin
					str_bad = 1'b1;
					return;
				end
				cp_acc = {5'd0, cp_acc[11:0], 4'(d)};
				if (cont_cnt < 2'd3) begin
					cont_cnt = cont_cnt + 2'd1;
					return;
				end
				cont_cnt = '0;
				if (cp_acc >= 21'hd800 && cp_acc <= 21'hdbff) begin
					cp_acc = 21'(32'h10000 + ((int'(cp_acc) - 32'hd800) << 10));
					ph     = PH_SBS;
				end else if (cp_acc >= 21'hdc00 && cp_acc <= 21'hdfff) begin
					str_bad = 1'b1;
				end else begin
					ph = PH_NORMAL;
					put_code_point(cp_acc, made);
				end
			end
			PH_SBS: begin
				if (c != CH_BSLASH) str_bad = 1'b1;
				else ph = PH_SU;
			end
			PH_SU: begin
				if (c != CH_U) begin
					str_bad = 1'b1;
				end else begin
					ph       = PH_SHEX;
					cont_cnt = '0;
				end
			end
			PH_SHEX: begin
				d = hex_digit(c);
				if (d < 0) begin
					str_bad = 1'b1;
					return;
				end
				case (cont_cnt)
					2'd0: if (d != 13) begin
						str_bad = 1'b1;
						return;
					end
					2'd1: begin
						if (d < 12) begin
							str_bad = 1'b1;
							return;
						end
						cp_acc = cp_acc | 21'((d & 3) << 8);
					end
					2'd2: cp_acc = cp_acc | 21'(d << 4);
					default: begin
						cp_acc   = cp_acc | 21'(d);
						cont_cnt = '0;
						ph       = PH_NORMAL;
						put_code_point(cp_acc, made);
						return;
					end
				endcase
				cont_cnt = cont_cnt + 2'd1;
			end
			PH_UTF8: begin
				if (c[7:6] != 2'b10) begin
					str_bad = 1'b1;
					return;
				end
				cp_acc = {cp_acc[14:0], c[5:0]};
				if (cont_cnt > 2'd1) begin
					cont_cnt = cont_cnt - 2'd1;
					return;
				end
				cont_cnt = '0;
				ph       = PH_NORMAL;
				minv = (seq_len == 2'd1) ? 32'h80 : (seq_len == 2'd2) ? 32'h800 : 32'h10000;
				if (cp_acc < minv || cp_acc > 21'h10ffff ||
				    (cp_acc >= 21'hd800 && cp_acc <= 21'hdfff)) begin
					str_bad = 1'b1;
					return;
				end
				put_code_point(cp_acc, made);
			end
			default: str_bad = 1'b1;
		endcase
	endfunction

	function automatic void string_restart();
		ph          = PH_NORMAL;
		cp_acc      = '0;
		cont_cnt    = '0;
		seq_len     = '0;
		n_written   = '0;
		had_visible = 1'b0;
		str_bad     = 1'b0;
	endfunction

	// Work out the beats that one accepted input beat causes and queue them.
	function automatic void decode_item(input logic [7:0] b, input logic p, input logic e);
		beat_t made[$];
		beat_t bt;
		logic ok;
		if (p && !str_bad) decode_byte(b, made);
		if (e) begin
			ok = !str_bad && ph == PH_NORMAL && n_written != 0 && had_visible;
			bt.data = 8'h00;
			bt.k    = ok ? KIND_ACCEPT : KIND_REJECT;
			bt.lst  = 1'b0;
			made.push_back(bt);
			if (ok) n_accept++;
			else n_reject++;
			string_restart();
		end
		if (made.size() > 0) made[made.size() - 1].lst = 1'b1;
		foreach (made[i]) decoded_q.push_back(made[i]);
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus generation
	// ---------------------------------------------------------------------

	function automatic logic [7:0] hex_char(input int d);
		if (d < 10) return 8'(32'h30 + d);
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(d - 10);
	endfunction

	function automatic logic [7:0] cont_byte();
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	function automatic logic [7:0] esc_letter(input int i);
		case (i)
			0: return CH_QUOTE;
			1: return CH_BSLASH;
			2: return CH_SLASH;
			3: return "n";
			4: return "r";
			5: return "t";
			6: return "b";
			default: return "f";
		endcase
	endfunction

	// Append a \uXXXX escape carrying the low 16 bits of v, in mixed case.
	function automatic void push_uesc(ref logic [7:0] q[$], input int unsigned v);
		int i;
		q.push_back(CH_BSLASH);
		q.push_back(CH_U);
		for (i = 3; i >= 0; i--) q.push_back(hex_char(int'((v >> (4 * i)) & 15)));
	endfunction

	function automatic void push_raw(ref logic [7:0] q[$], input int unsigned cp);
		logic [3:0][7:0] b;
		int n, i;
		n = utf8_encode(cp, b);
		for (i = 0; i < n; i++) q.push_back(b[i]);
	endfunction

	// Append one well-formed token.
	function automatic void push_good(ref logic [7:0] q[$]);
		int unsigned cp;
		case ($urandom_range(0, 6))
			0, 1: begin
				cp = ($urandom_range(0, 7) == 0) ? 32'h20 : $urandom_range(33, 126);
				if (cp == CH_BSLASH) q.push_back(CH_BSLASH);
				q.push_back(8'(cp));
			end
			2: begin
				q.push_back(CH_BSLASH);
				q.push_back(esc_letter($urandom_range(0, 7)));
			end
			3: begin
				cp = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 32'h7ff)
				                                 : $urandom_range(32, 32'hffff);
				if (cp >= 32'hd800 && cp <= 32'hdfff) cp = cp - 32'h1000;
				push_uesc(q, cp);
			end
			4: begin
				cp = $urandom_range(0, 32'hfffff);
				push_uesc(q, 32'hd800 + (cp >> 10));
				push_uesc(q, 32'hdc00 + (cp & 32'h3ff));
			end
			5: begin
				cp = $urandom_range(0, 1) ? $urandom_range(32'h80, 32'h7ff)
				                          : $urandom_range(32'h800, 32'hffff);
				if (cp >= 32'hd800 && cp <= 32'hdfff) cp = cp + 32'h800;
				push_raw(q, cp);
			end
			default: push_raw(q, $urandom_range(32'h10000, 32'h10ffff));
		endcase
	endfunction

	// Append one malformed token.
	function automatic void push_bad(ref logic [7:0] q[$]);
		case ($urandom_range(0, 9))
			0: q.push_back(8'($urandom));
			1: q.push_back(($urandom_range(0, 3) == 0) ? 8'h7f : 8'($urandom_range(0, 31)));
			2: begin
				q.push_back(CH_BSLASH);
				q.push_back(8'($urandom));
			end
			3: begin
				// corrupt one hex digit
				push_uesc(q, $urandom);
				q[q.size() - 1 - $urandom_range(0, 3)] = 8'($urandom);
			end
			4: push_uesc(q, $urandom_range(32'hdc00, 32'hdfff));
			5: begin
				// high surrogate, usually with no proper low half behind it
				push_uesc(q, $urandom_range(32'hd800, 32'hdbff));
				case ($urandom_range(0, 3))
					0: q.push_back(8'($urandom_range(32, 126)));
					1: begin
						q.push_back(CH_BSLASH);
						q.push_back(8'($urandom));
					end
					2: push_uesc(q, $urandom);
					default: push_uesc(q, $urandom_range(32'hd000, 32'hdfff));
				endcase
			end
			6: begin
				// overlong forms
				case ($urandom_range(0, 2))
					0: q.push_back(8'($urandom_range(32'hc0, 32'hc1)));
					1: begin
						q.push_back(8'he0);
						q.push_back(8'($urandom_range(32'h80, 32'h9f)));
					end
					default: begin
						q.push_back(8'hf0);
						q.push_back(8'($urandom_range(32'h80, 32'h8f)));
						q.push_back(cont_byte());
					end
				endcase
				q.push_back(cont_byte());
			end
			7: begin
				// above the last code point
				q.push_back(8'($urandom_range(32'hf4, 32'hff)));
				q.push_back(8'($urandom_range(32'h90, 32'hbf)));
				q.push_back(cont_byte());
				q.push_back(cont_byte());
			end
			8: begin
				// raw UTF-16 surrogate
				q.push_back(8'hed);
				q.push_back(8'($urandom_range(32'ha0, 32'hbf)));
				q.push_back(cont_byte());
			end
			default: begin
				// lead byte cut short by a non-continuation byte
				q.push_back(8'($urandom_range(32'hc2, 32'hf4)));
				q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 32'h7f))
				                                 : 8'($urandom_range(32'hc0, 32'hff)));
			end
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------------

	// Offer one input beat, after a random gap while idle_on is set, hold it
	// until accepted, then predict what it causes.
	task automatic send_item(input logic [7:0] b, input logic p, input logic e);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		in_byte       <= b;
		byte_present  <= p;
		end_of_string <= e;
		do @(posedge clk); while (in_stall);
		decode_item(b, p, e);
		n_items++;
	endtask

	// Send a byte sequence as one string. Sprinkle empty beats inside it and
	// sometimes close the string with an empty end beat.
	task automatic send_seq(ref logic [7:0] sb[$]);
		logic split;
		split = (sb.size() == 0) || ($urandom_range(0, 5) == 0);
		foreach (sb[i]) begin
			if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
			send_item(sb[i], 1'b1, !split && i == sb.size() - 1);
		end
		if (split) send_item(8'($urandom), 1'b0, 1'b1);
		n_strings++;
	endtask

	// Build and send one random string: mostly well formed, some with one
	// broken token, a few pure noise.
	task automatic send_string(input int ntok);
		logic [7:0] sb[$];
		int pick, bad_at, t;
		idle_on = ($urandom_range(0, 3) != 0);
		pick    = $urandom_range(0, 7);
		bad_at  = (pick == 1) ? $urandom_range(0, ntok - 1) : -1;
		for (t = 0; t < ntok; t++) begin
			if (pick == 0) sb.push_back(8'($urandom));
			else if (t == bad_at) push_bad(sb);
			else push_good(sb);
		end
		send_seq(sb);
	endtask

	// Drop input valid and wait until every expected beat has left, plus
	// a safety margin for beats that cause no output.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [10:0] v);
		wait_drained();
		cfg_valid    <= 1'b1;
		out_capacity <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_reg = v;
	endtask

	// ---------------------------------------------------------------------
	// Receive side and monitor
	// ---------------------------------------------------------------------

	// Stall a random number of cycles before each beat, or for a long
	// stretch when the pressure test asks for it.
	initial begin : rx_pace
		int w;
		@(posedge arst_n);
		forever begin
			if (hold_req > 0) begin
				w = hold_req;
				hold_req = 0;
				long_holds++;
			end else begin
				w = idle_on ? $urandom_range(0, 3) : 0;
			end
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	task automatic report(input string msg);
		if (n_errors < 40) $display("mismatch @%0t: %s", $realtime, msg);
		n_errors++;
	endtask

	// Check each accepted output beat against the oldest expectation.
	always @(posedge clk) begin : check_beats
		beat_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			n_beats++;
			if (decoded_q.size() == 0) begin
				report($sformatf("unexpected beat byte %h kind %0d last %0d",
					out_byte, kind, last));
			end else begin
				want = decoded_q.pop_front();
				if (out_byte !== want.data)
					report($sformatf("out_byte %h, want %h", out_byte, want.data));
				if (kind !== want.k)
					report($sformatf("kind %0d, want %0d", kind, want.k));
				if (last !== want.lst)
					report($sformatf("last %0d, want %0d", last, want.lst));
			end
		end
	end

	// Bound the run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycles, decoded_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Hand-picked strings: field extremes, several escape classes, the verdict
	// corner cases and the main error paths.
	task automatic test_edge_strings();
		logic [7:0] sb[$];
		idle_on = 1'b1;
		send_item(8'hff, 1'b0, 1'b1);           // empty string: reject
		sb = '{8'h00};                           // NUL is a control char
		send_seq(sb);
		sb = '{8'hff};                           // never a lead byte
		send_seq(sb);
		sb = '{8'h7e};                           // top printable ASCII: accept
		send_seq(sb);
		sb = '{8'h7f};                           // DEL
		send_seq(sb);
		sb = '{CH_BSLASH, "t"};                  // only whitespace out: reject
		send_seq(sb);
		sb = '{CH_BSLASH, CH_QUOTE, CH_BSLASH, "q"}; // unknown escape after data
		send_seq(sb);
		sb = '{8'hf4, 8'h8f, 8'hbf, 8'hbf};     // highest code point
		send_seq(sb);
		sb = '{8'hc3};                           // sequence left open
		send_seq(sb);
		sb = '{8'hed, 8'ha0, 8'h80};             // raw surrogate
		send_seq(sb);
		sb = '{CH_BSLASH};                       // escape left open
		send_seq(sb);
		sb = '{CH_BSLASH, CH_U, "D", "c", "0", "0"}; // lone low surrogate
		send_seq(sb);
		sb = '{CH_BSLASH, CH_U, "0", "g"};       // bad hex digit
		send_seq(sb);
		// an empty beat in mid-string changes nothing
		send_item("x", 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b0);
		send_item("y", 1'b1, 1'b1);
	endtask

	task automatic test_random_default();
		while (n_items < 110) send_string($urandom_range(1, 10));
	endtask

	// Walk the capacity register through its corners: zero and one reject
	// everything, two fits one byte, small values overflow often, and the
	// top of the field acts as the maximum.
	task automatic test_capacity_limits();
		int stop;
		write_capacity(11'd0);
		repeat (3) send_string($urandom_range(1, 3));
		write_capacity(11'd1);
		repeat (3) send_string($urandom_range(1, 3));
		write_capacity(11'd2);
		repeat (8) send_string($urandom_range(1, 2));
		repeat (2) begin
			write_capacity(11'($urandom_range(3, 12)));
			stop = n_items + 30;
			while (n_items < stop) send_string($urandom_range(1, 8));
		end
		write_capacity(11'h7ff);
		stop = n_items + 40;
		while (n_items < stop) send_string($urandom_range(1, 12));
	endtask

	// Hold the output for a long stretch while input keeps coming, so the
	// job queue fills and the input side stalls.
	task automatic test_backpressure();
		logic [7:0] sb[$];
		int t;
		write_capacity(11'd1024);
		for (t = 0; t < 14; t++) push_good(sb);
		hold_req = LONG_HOLD;
		idle_on  = 1'b0;
		foreach (sb[i]) send_item(sb[i], 1'b1, i == sb.size() - 1);
		n_strings++;
		while (n_items < 400) send_string($urandom_range(1, 10));
	endtask

	initial begin
		cap_reg = 11'd256;
		string_restart();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edge_strings();
		test_random_default();
		test_capacity_limits();
		test_backpressure();
		wait_drained();

		$display("%0d input beats in %0d strings: %0d accepted, %0d rejected, %0d beats checked",
			n_items, n_strings, n_accept, n_reject, n_beats);
		$display("capacity 256, 0, 1, 2, small, 2047 and 1024; %0d long output holds",
			long_holds);
		if (n_errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8_check_core.sv
test/tb.sv
